// ===== hdl/dtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dtrs_pkg
// Shared types and constants of the dirty-tile rectangle scanner.
// ----------------------------------------------------------------------------
package dtrs_pkg;

    localparam int MAX_TILES_ACROSS = 64;
    localparam int MAX_DISPLAY_DIM  = 2048;

    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN     = 3'd5;

    localparam logic [11:0] DISPLAY_WIDTH_RST  = 12'd320;
    localparam logic [11:0] DISPLAY_HEIGHT_RST = 12'd240;
    localparam logic [8:0]  TILE_WIDTH_RST     = 9'd16;
    localparam logic [8:0]  TILE_HEIGHT_RST    = 9'd16;
    localparam logic [6:0]  TILES_ACROSS_RST   = 7'd20;
    localparam logic [6:0]  TILES_DOWN_RST     = 7'd15;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture item, compute tile row start
        logic setup;    // row clip and framebuffer row base
        logic advance;  // examine one tile column
        logic flush;    // send held rectangle as last of the row
    } dtrs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic row_vis;
        logic scan_done;
        logic col_hit;
        logic pend_valid;
        logic out_free;
    } dtrs_sts_t;

endpackage

// ===== hdl/dirty_tile_rect_scanner.sv =====
// ----------------------------------------------------------------------------
// dirty_tile_rect_scanner
// Turns dirty-tile bitmap rows into clipped pixel rectangles with offsets.
// ----------------------------------------------------------------------------
// Each item is one tile row of the dirty bitmap; the block walks its tile
// columns one per cycle, pausing while a dirty tile would displace the held
// rectangle and the output register is full and not taken. It sends one
// rectangle per dirty, visible tile, flagging the last one of the row. An
// item goes through intake and row setup, then a walk over the tile columns
// up to the last column that still starts inside the display (at most
// tiles_across, at most 64); then the walk end is seen and the final
// rectangle is sent once the output register is free. Configuration writes
// are taken at any time but must land while no item is in flight.
module dirty_tile_rect_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dtrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_dirty_mask,
    input  logic        s_new_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_rect_x_start,
    output logic [10:0] m_rect_y_start,
    output logic [11:0] m_rect_x_end,
    output logic [11:0] m_rect_y_end,
    output logic [21:0] m_fb_offset,
    output logic        m_last_in_row
);
    import dtrs_pkg::*;

    dtrs_cmd_t cmd;
    dtrs_sts_t sts;

    dtrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dtrs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_dirty_mask   (s_dirty_mask),
        .s_new_frame    (s_new_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rect_x_start (m_rect_x_start),
        .m_rect_y_start (m_rect_y_start),
        .m_rect_x_end   (m_rect_x_end),
        .m_rect_y_end   (m_rect_y_end),
        .m_fb_offset    (m_fb_offset),
        .m_last_in_row  (m_last_in_row),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ===== hdl/dtrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtrs_ctrl
// Sequencer: item intake, row setup, column scan and final flush.
// ----------------------------------------------------------------------------
module dtrs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dtrs_pkg::dtrs_sts_t sts,
    output dtrs_pkg::dtrs_cmd_t cmd
);
    import dtrs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!sts.row_vis || sts.scan_done) begin
                    state_next = ST_FLUSH;
                end else if (!(sts.col_hit && sts.pend_valid && !sts.out_free)) begin
                    cmd.advance = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> (sts.pend_valid && sts.out_free))
        else $error("flush without a held rectangle or free output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && sts.col_hit && sts.pend_valid) |-> sts.out_free)
        else $error("scan step would overwrite the output register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_SETUP))
        else $error("item intake not followed by row setup");

endmodule

// ===== hdl/dtrs_datapath.sv =====
// ----------------------------------------------------------------------------
// dtrs_datapath
// Config registers, tile row counter, column walker and rectangle registers.
// ----------------------------------------------------------------------------
module dtrs_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [dtrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [11:0]          cfg_data,
    input  logic [63:0]          s_dirty_mask,
    input  logic                 s_new_frame,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [10:0]          m_rect_x_start,
    output logic [10:0]          m_rect_y_start,
    output logic [11:0]          m_rect_x_end,
    output logic [11:0]          m_rect_y_end,
    output logic [21:0]          m_fb_offset,
    output logic                 m_last_in_row,
    input  dtrs_pkg::dtrs_cmd_t  cmd,
    output dtrs_pkg::dtrs_sts_t  sts
);
    import dtrs_pkg::*;

    localparam logic [11:0] DIM_MAX  = 12'(MAX_DISPLAY_DIM);
    localparam logic [6:0]  COLS_MAX = 7'(MAX_TILES_ACROSS);

    // configuration
    logic [11:0] dw_reg, dh_reg;
    logic [8:0]  tw_reg, th_reg;
    logic [6:0]  ta_reg, td_reg;

    // per-item state
    logic [5:0]  row_cnt_reg;
    logic [63:0] mask_reg;
    logic [14:0] y0_reg;
    logic [11:0] y1_reg;
    logic        row_vis_reg;
    logic [21:0] base_reg;
    logic [6:0]  col_reg;
    logic [14:0] x0_reg;

    // held rectangle, waiting to learn whether it is the last one
    logic        pend_valid_reg;
    logic [10:0] pend_x0_reg;
    logic [11:0] pend_x1_reg;
    logic [21:0] pend_fb_reg;

    // output register
    logic        out_valid_reg;
    logic [10:0] out_x0_reg, out_y0_reg;
    logic [11:0] out_x1_reg, out_y1_reg;
    logic [21:0] out_fb_reg;
    logic        out_last_reg;

    logic [11:0] w_eff, h_eff;
    logic [6:0]  cols_eff;
    logic [5:0]  row_sel;
    logic [6:0]  row_inc;
    logic [14:0] y0_prod;
    logic [15:0] y0_plus;
    logic [22:0] base_full;
    logic [15:0] x0_plus;
    logic [11:0] x1_new;
    logic        scan_done, col_hit, out_free, out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dw_reg <= DISPLAY_WIDTH_RST;
            dh_reg <= DISPLAY_HEIGHT_RST;
            tw_reg <= TILE_WIDTH_RST;
            th_reg <= TILE_HEIGHT_RST;
            ta_reg <= TILES_ACROSS_RST;
            td_reg <= TILES_DOWN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DISPLAY_WIDTH:  dw_reg <= cfg_data;
                REG_DISPLAY_HEIGHT: dh_reg <= cfg_data;
                REG_TILE_WIDTH:     tw_reg <= cfg_data[8:0];
                REG_TILE_HEIGHT:    th_reg <= cfg_data[8:0];
                REG_TILES_ACROSS:   ta_reg <= cfg_data[6:0];
                REG_TILES_DOWN:     td_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign w_eff    = (dw_reg > DIM_MAX) ? DIM_MAX : dw_reg;
    assign h_eff    = (dh_reg > DIM_MAX) ? DIM_MAX : dh_reg;
    assign cols_eff = (ta_reg > COLS_MAX) ? COLS_MAX : ta_reg;

    assign row_sel = s_new_frame ? 6'd0 : row_cnt_reg;
    assign row_inc = {1'b0, row_sel} + 7'd1;
    assign y0_prod = 15'(row_sel) * 15'(th_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
        end else if (cmd.load) begin
            row_cnt_reg <= (row_inc >= td_reg) ? 6'd0 : row_inc[5:0];
        end
    end

    // row setup: clip and framebuffer row base
    assign y0_plus   = {1'b0, y0_reg} + 16'(th_reg);
    assign base_full = {12'd0, y0_reg[10:0]} * {11'd0, w_eff};

    // column walk
    assign x0_plus   = {1'b0, x0_reg} + 16'(tw_reg);
    assign x1_new    = (x0_plus > 16'(w_eff)) ? w_eff : x0_plus[11:0];
    // x0 only grows, so the first column past the display edge ends the row
    assign scan_done = (col_reg >= cols_eff) || (x0_reg >= 15'(w_eff)) || (tw_reg == 9'd0);
    assign col_hit   = !scan_done && mask_reg[col_reg[5:0]];
    assign out_free  = !out_valid_reg || m_ready;
    assign out_load  = (cmd.advance && col_hit && pend_valid_reg) || cmd.flush;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mask_reg <= s_dirty_mask;
            y0_reg   <= y0_prod;
        end
        if (cmd.setup) begin
            y1_reg      <= (y0_plus > 16'(h_eff)) ? h_eff : y0_plus[11:0];
            row_vis_reg <= (y0_reg < 15'(h_eff)) && (th_reg != 9'd0);
            base_reg    <= base_full[21:0];
            col_reg     <= '0;
            x0_reg      <= '0;
        end
        if (cmd.advance) begin
            col_reg <= col_reg + 7'd1;
            x0_reg  <= x0_plus[14:0];
            if (col_hit) begin
                pend_x0_reg <= x0_reg[10:0];
                pend_x1_reg <= x1_new;
                pend_fb_reg <= base_reg + 22'(x0_reg[10:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.load || cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.advance && col_hit) begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x0_reg   <= pend_x0_reg;
            out_y0_reg   <= y0_reg[10:0];
            out_x1_reg   <= pend_x1_reg;
            out_y1_reg   <= y1_reg;
            out_fb_reg   <= pend_fb_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_rect_x_start = out_x0_reg;
    assign m_rect_y_start = out_y0_reg;
    assign m_rect_x_end   = out_x1_reg;
    assign m_rect_y_end   = out_y1_reg;
    assign m_fb_offset    = out_fb_reg;
    assign m_last_in_row  = out_last_reg;

    assign sts.row_vis    = row_vis_reg;
    assign sts.scan_done  = scan_done;
    assign sts.col_hit    = col_hit;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> (col_reg < COLS_MAX))
        else $error("column walker ran past the widest row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ({1'b0, out_x0_reg} < out_x1_reg))
        else $error("empty rectangle sent");

endmodule
